@@ rtl/core/ucud_pkg.sv @@
// Package for the Unicode code unit decoder: unit-mode codes, result type,
// surrogate constants and the UTF-8 length and offset tables.
// No dependencies.
`default_nettype none

package ucud_pkg;

  localparam int unsigned UNIT_W = 32;
  localparam int unsigned POINT_W = 32;

  typedef enum logic [1:0] {
    MODE_UTF8  = 2'd0,
    MODE_UTF16 = 2'd1,
    MODE_UTF32 = 2'd2
  } unit_mode_t;

  // Top six bits of a 16-bit unit that mark high and low surrogates.
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
  localparam logic [31:0] SUPPLEMENTARY_BASE = 32'h0001_0000;

  typedef struct packed {
    logic [POINT_W-1:0] code_point;
    logic               end_of_run;
  } result_t;

  // Sequence length set by a UTF-8 lead byte.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    priority if (b < 8'hC0) len = 3'd1;
    else if (b < 8'hE0)     len = 3'd2;
    else if (b < 8'hF0)     len = 3'd3;
    else if (b < 8'hF8)     len = 3'd4;
    else if (b < 8'hFC)     len = 3'd5;
    else                    len = 3'd6;
    return len;
  endfunction

  // Offset subtracted from an assembled sequence of the given length.
  function automatic logic [31:0] seq_offset(input logic [2:0] len);
    logic [31:0] off;
    unique case (len)
      3'd2:    off = 32'h0000_3080;
      3'd3:    off = 32'h000E_2080;
      3'd4:    off = 32'h03C8_2080;
      3'd5:    off = 32'hFA08_2080;
      3'd6:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ucud_unit_if.sv @@
// Input channel of the Unicode code unit decoder: valid/ready plus one code unit.
// Depends on ucud_pkg for the unit width.
`default_nettype none

interface ucud_unit_if;
  logic                        valid;
  logic                        ready;
  logic [ucud_pkg::UNIT_W-1:0] code_unit;
  logic                        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ucud_point_if.sv @@
// Output channel of the Unicode code unit decoder: valid/ready plus one code point.
// Depends on ucud_pkg for the code point width.
`default_nettype none

interface ucud_point_if;
  logic                         valid;
  logic                         ready;
  logic [ucud_pkg::POINT_W-1:0] code_point;
  logic                         end_of_run;

  modport source (output valid, output code_point, output end_of_run, input ready);
  modport sink (input valid, input code_point, input end_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/core/unicode_code_unit_decoder_top.sv @@
// Unicode code unit decoder top level: UTF-8 / UTF-16 / UTF-32 units in, code points out.
// Depends on ucud_pkg, ucud_unit_if and ucud_point_if.
//
// Takes one code unit per transaction on unit_in and returns code points on
// point_out. Throughput is one unit per clock while point_out.ready is high: the
// decode is a single pass of logic from the input transaction and the decode state
// straight into a three-entry result queue, which registers each result as its unit
// is taken. unit_in.ready is high while at most one result is queued, which leaves
// room for the two results one unit can cause; the queue drains one result per cycle
// while point_out.ready is high, so a unit that yields two results (an unpaired high
// surrogate) stalls unit_in until the queue drains, and otherwise the block runs at
// one unit per cycle. end_of_run marks the last result caused by a unit; a unit that
// completes nothing (a UTF-8 lead or continuation byte, a held high surrogate)
// produces no transaction. The unit width is chosen by writing cfg_data with
// cfg_we high (0 UTF-8, 1 UTF-16, 2 UTF-32, 3 behaves as UTF-32); a write also
// drops any partial sequence or held surrogate and must only be made while the
// block is idle. UTF-8 sequences are not validated: the lead byte sets the
// length, continuation bytes are shifted in six bits at a time, and the length
// offset is subtracted modulo 2^32. last_unit flushes a held surrogate and drops
// an incomplete UTF-8 sequence.
`default_nettype none

module unicode_code_unit_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  ucud_unit_if.sink       unit_in,
  ucud_point_if.source    point_out,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_data
);

  // Configuration and decode state.
  ucud_pkg::unit_mode_t mode;
  logic [31:0] accumulator, accumulator_next;
  logic [2:0]  bytes_remaining, bytes_remaining_next;
  logic [2:0]  sequence_length, sequence_length_next;
  logic [15:0] held_high, held_high_next;
  logic        pending, pending_next;

  // Result queue, head at entry 0.
  ucud_pkg::result_t q [3];
  ucud_pkg::result_t q_next [3];
  logic [1:0] cnt, cnt_next;

  // Results of the current unit.
  logic [31:0] res0, res1;
  logic [1:0]  n_res;

  logic push, pop;
  logic [1:0] base;

  assign unit_in.ready        = (cnt <= 2'd1);
  assign point_out.valid      = (cnt != 2'd0);
  assign point_out.code_point = q[0].code_point;
  assign point_out.end_of_run = q[0].end_of_run;

  assign push = unit_in.valid && unit_in.ready;
  assign pop  = point_out.valid && point_out.ready;

  // Single decode pass: state plus unit gives up to two results and the new state.
  always_comb begin : decode
    logic [7:0]  b;
    logic [15:0] u;
    logic        is_high, is_low, done;
    logic [2:0]  len_sel, rem_step;
    logic [31:0] acc_step;

    b        = unit_in.code_unit[7:0];
    u        = unit_in.code_unit[15:0];
    is_high  = (u[15:10] == ucud_pkg::HIGH_SURR_TAG);
    is_low   = (u[15:10] == ucud_pkg::LOW_SURR_TAG);
    done     = 1'b0;
    len_sel  = sequence_length;
    rem_step = bytes_remaining;
    acc_step = accumulator;

    res0 = '0;
    res1 = '0;
    n_res = 2'd0;
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    held_high_next       = held_high;
    pending_next         = pending;

    unique case (mode)
      ucud_pkg::MODE_UTF8: begin
        if (bytes_remaining == 3'd0) begin
          len_sel  = ucud_pkg::lead_length(b);
          acc_step = {24'd0, b};
          rem_step = len_sel - 3'd1;
        end else begin
          acc_step = {accumulator[25:0], 6'd0} + {24'd0, b};
          rem_step = bytes_remaining - 3'd1;
        end
        if (rem_step == 3'd0) begin
          res0  = acc_step - ucud_pkg::seq_offset(len_sel);
          n_res = 2'd1;
          accumulator_next     = '0;
          bytes_remaining_next = '0;
          sequence_length_next = '0;
        end else if (unit_in.last_unit) begin
          // Drop the truncated sequence.
          accumulator_next     = '0;
          bytes_remaining_next = '0;
          sequence_length_next = '0;
          held_high_next       = '0;
          pending_next         = 1'b0;
        end else begin
          accumulator_next     = acc_step;
          bytes_remaining_next = rem_step;
          sequence_length_next = len_sel;
        end
      end
      ucud_pkg::MODE_UTF16: begin
        if (pending) begin
          if (is_low) begin
            res0 = ucud_pkg::SUPPLEMENTARY_BASE + {12'd0, held_high[9:0], u[9:0]};
            done = 1'b1;
          end else begin
            res0 = {16'd0, held_high};
          end
          n_res          = 2'd1;
          pending_next   = 1'b0;
          held_high_next = '0;
        end
        if (!done) begin
          if (is_high) begin
            held_high_next = u;
            pending_next   = 1'b1;
          end else begin
            if (n_res == 2'd0) res0 = {16'd0, u};
            else               res1 = {16'd0, u};
            n_res = n_res + 2'd1;
          end
        end
        // Flush a surrogate still held at the end of the string.
        if (unit_in.last_unit && pending_next) begin
          if (n_res == 2'd0) res0 = {16'd0, held_high_next};
          else               res1 = {16'd0, held_high_next};
          n_res          = n_res + 2'd1;
          pending_next   = 1'b0;
          held_high_next = '0;
        end
      end
      default: begin
        res0  = unit_in.code_unit;
        n_res = 2'd1;
      end
    endcase
  end

  // Queue update: shift out the head on pop, then append new results behind it.
  assign base = cnt - {1'b0, pop};

  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = pop ? q[2] : q[1];
    q_next[2] = q[2];
    if (push && n_res != 2'd0) begin
      unique case (base)
        2'd0: begin
          q_next[0] = '{code_point: res0, end_of_run: (n_res == 2'd1)};
          q_next[1] = '{code_point: res1, end_of_run: 1'b1};
        end
        2'd1: begin
          q_next[1] = '{code_point: res0, end_of_run: (n_res == 2'd1)};
          q_next[2] = '{code_point: res1, end_of_run: 1'b1};
        end
        default: begin
          q_next[2] = '{code_point: res0, end_of_run: 1'b1};
        end
      endcase
    end
    cnt_next = base + (push ? n_res : 2'd0);
  end

  // Queue payload holds no reset; the count guards it.
  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= ucud_pkg::MODE_UTF8;
      accumulator     <= '0;
      bytes_remaining <= '0;
      sequence_length <= '0;
      held_high       <= '0;
      pending         <= 1'b0;
      cnt             <= '0;
    end else begin
      cnt <= cnt_next;
      if (cfg_we) begin
        // Mode change drops anything in progress.
        mode            <= ucud_pkg::unit_mode_t'(cfg_data);
        accumulator     <= '0;
        bytes_remaining <= '0;
        sequence_length <= '0;
        held_high       <= '0;
        pending         <= 1'b0;
      end else if (push) begin
        accumulator     <= accumulator_next;
        bytes_remaining <= bytes_remaining_next;
        sequence_length <= sequence_length_next;
        held_high       <= held_high_next;
        pending         <= pending_next;
      end
    end
  end

  // A held surrogate exists only in UTF-16 mode.
  assert property (@(posedge clk) disable iff (rst)
    pending |-> mode == ucud_pkg::MODE_UTF16)
    else $error("surrogate held outside UTF-16 mode");

  // An open UTF-8 sequence always has fewer bytes left than its length.
  assert property (@(posedge clk) disable iff (rst)
    bytes_remaining != 3'd0 |->
      (mode == ucud_pkg::MODE_UTF8 && sequence_length > bytes_remaining))
    else $error("inconsistent UTF-8 sequence state");

  // A pass-through unit always shows a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (push && mode == ucud_pkg::MODE_UTF32 && !cfg_we) |=> point_out.valid)
    else $error("pass-through unit produced no result");

  // After a push, all three entries are full only if two results joined one without a pop.
  assert property (@(posedge clk) disable iff (rst)
    push |=> cnt != 2'd3 || $past(cnt) == 2'd1 && $past(n_res) == 2'd2 && !$past(pop))
    else $error("result queue overfilled");

endmodule

`default_nettype wire
